// File: design/source_byte_tokenizer_unit_defines.svh
`ifndef SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define SBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sbt_pkg.sv
package sbt_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;
	localparam int unsigned OFFSET_BITS_DEF = 32;
	localparam int unsigned LINE_BITS_DEF   = 24;
	localparam int unsigned COLUMN_BITS_DEF = 16;

	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_END  = 1'b1;

	typedef logic [31:0] offset_field_t;
	typedef logic [15:0] length_field_t;
	typedef logic [23:0] line_field_t;
	typedef logic [15:0] column_field_t;

	typedef enum logic [3:0] {
		RK_IDENT      = 4'd0,
		RK_HEX        = 4'd1,
		RK_BIN        = 4'd2,
		RK_OCT        = 4'd3,
		RK_FLOAT      = 4'd4,
		RK_DEC        = 4'd5,
		RK_OPER       = 4'd6,
		RK_STRING     = 4'd7,
		RK_CHAR       = 4'd8,
		RK_BAD_BIN    = 4'd9,
		RK_BAD_OCT    = 4'd10,
		RK_OPEN_STR   = 4'd11,
		RK_OPEN_CHR   = 4'd12,
		RK_UNEXP_END  = 4'd13,
		RK_DONE       = 4'd14
	} res_kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} src_item_t;

	typedef struct packed {
		logic [3:0]    result_kind;
		offset_field_t start_offset;
		length_field_t token_length;
		line_field_t   start_line;
		column_field_t start_column;
		logic          last_of_run;
	} res_item_t;

endpackage

// File: design/source_byte_tokenizer_unit.sv
// Timing: an accepted item is held in the input register until the output queue has room;
// its results are then written into the output queue and offered from there.
// Throughput: one item per cycle while the four-entry output queue holds two results or
// fewer; a byte gives at most one result, an end item gives up to two.
// Reset: arst_n clears mode, token, position counters, the input register and the result queue at once.
`include "source_byte_tokenizer_unit_defines.svh"

module source_byte_tokenizer_unit #(
	parameter int unsigned LENGTH_BITS = sbt_pkg::LENGTH_BITS_DEF,
	parameter int unsigned OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF,
	parameter int unsigned LINE_BITS   = sbt_pkg::LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS = sbt_pkg::COLUMN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  sbt_pkg::src_item_t src_data,
	output logic              res_valid,
	input  logic              res_ready,
	output sbt_pkg::res_item_t res_data
);

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [3:0] {
		M_DEF, M_IDENT, M_HEX, M_BIN, M_OCT, M_FLOAT, M_DEC, M_ZERO,
		M_OPER, M_STR, M_CHR, M_LCOM, M_BCOM, M_HALT
	} mode_t;

	typedef struct packed {
		logic [7:0]             first;
		logic [7:0]             last;
		logic [LENGTH_BITS-1:0] count;
	} tok_t;

	typedef struct packed {
		mode_t                  next;
		tok_t                   tok;
		logic                   emit;
		logic                   err;
		logic                   rep;
		logic                   start;
		sbt_pkg::res_kind_t     kind;
		logic [LENGTH_BITS-1:0] len;
	} step_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic is_sp(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "+") ||
			(c == "-") || (c == "*") || (c == "/") || (c == "%") || (c == "&") ||
			(c == "|") || (c == "^") || (c == "?") || (c == ":") || (c == ",") ||
			(c == ".") || (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
			(c == "[") || (c == "]") || (c == ";") || (c == "~");
	endfunction

	function automatic logic is_dbl(input logic [7:0] c);
		return (c == ":") || (c == "+") || (c == "-") || (c == "&") || (c == "|") ||
			(c == "?") || (c == "<") || (c == ">");
	endfunction

	function automatic logic is_eq2(input logic [7:0] c);
		return (c == "<") || (c == ">") || (c == "=") || (c == "!") || (c == "+") ||
			(c == "-") || (c == "/") || (c == "*") || (c == "%");
	endfunction

	function automatic logic is_eq3(input logic [7:0] c);
		return (c == "<") || (c == ">") || (c == "?");
	endfunction

	function automatic step_t lex_step(input mode_t m, input tok_t t, input logic [7:0] c);
		step_t      s;
		logic       add;
		logic       clr;
		logic       ok;
		logic       nz;
		logic       k1;
		logic       k2;
		logic [7:0] q;
		nz  = |t.count;
		k1  = t.count == LENGTH_BITS'(1);
		k2  = t.count == LENGTH_BITS'(2);
		add = 1'b0;
		clr = 1'b0;
		ok  = 1'b0;
		q   = (m == M_STR) ? CH_DQUOTE : CH_SQUOTE;
		s.next  = m;
		s.tok   = t;
		s.emit  = 1'b0;
		s.err   = 1'b0;
		s.rep   = 1'b0;
		s.start = 1'b0;
		s.kind  = sbt_pkg::RK_IDENT;
		unique case (m)
			M_DEF: begin
				add = 1'b1;
				priority if (c == CH_DQUOTE) s.next = M_STR;
				else if (c == CH_SQUOTE) s.next = M_CHR;
				else if (c == "0") s.next = M_ZERO;
				else if (is_op(c)) s.next = M_OPER;
				else if (is_dig(c)) s.next = M_DEC;
				else if (is_sp(c)) begin
					add = 1'b0;
					clr = 1'b1;
				end else s.next = M_IDENT;
			end
			M_IDENT: begin
				if (is_op(c) || is_sp(c)) begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_IDENT;
				end else add = 1'b1;
			end
			M_HEX: begin
				if (is_hex(c)) add = 1'b1;
				else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_HEX;
				end
			end
			M_BIN: begin
				priority if ((c == "0") || (c == "1")) add = 1'b1;
				else if (is_dig(c)) begin
					s.err = 1'b1; s.kind = sbt_pkg::RK_BAD_BIN;
				end else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_BIN;
				end
			end
			M_OCT: begin
				priority if ((c >= "0") && (c <= "7")) add = 1'b1;
				else if (is_dig(c)) begin
					s.err = 1'b1; s.kind = sbt_pkg::RK_BAD_OCT;
				end else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_OCT;
				end
			end
			M_FLOAT: begin
				if (is_dig(c)) add = 1'b1;
				else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_FLOAT;
				end
			end
			M_DEC: begin
				priority if (is_dig(c)) add = 1'b1;
				else if (c == ".") begin
					add = 1'b1; s.next = M_FLOAT;
				end else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_DEC;
				end
			end
			M_ZERO: begin
				priority if (c == ".") begin
					add = 1'b1; s.next = M_FLOAT;
				end else if (c == "b") begin
					add = 1'b1; s.next = M_BIN;
				end else if (c == "x") begin
					add = 1'b1; s.next = M_HEX;
				end else if (is_dig(c)) begin
					s.next = M_OCT; s.rep = 1'b1;
				end else begin
					s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_DEC;
				end
			end
			M_OPER: begin
				if (!nz) add = 1'b1;
				else if ((t.first == ".") && is_dig(c)) begin
					add = 1'b1; s.next = M_FLOAT;
				end else if ((t.first == "/") && k1 && (c == "/")) s.next = M_LCOM;
				else if ((t.first == "/") && k1 && (c == "*")) s.next = M_BCOM;
				else begin
					ok = ((t.first == c) && k1 && is_dbl(c)) ||
						((c == "=") && ((k1 && is_eq2(t.first)) || (k2 && is_eq3(t.first)))) ||
						((t.first == "-") && (c == ">") && k1);
					if (ok) add = 1'b1;
					else begin
						s.emit = 1'b1; s.rep = 1'b1; s.kind = sbt_pkg::RK_OPER;
					end
				end
			end
			M_STR, M_CHR: begin
				add = 1'b1;
				if ((c == q) && !(nz && (t.last == CH_BSLASH))) begin
					s.emit = 1'b1;
					s.next = M_DEF;
					s.kind = (m == M_STR) ? sbt_pkg::RK_STRING : sbt_pkg::RK_CHAR;
				end
			end
			M_LCOM: begin
				clr = 1'b1;
				if (c == CH_NL) s.next = M_DEF;
			end
			M_BCOM: begin
				if ((c == "/") && nz && (t.last == "*")) begin
					clr = 1'b1; s.next = M_DEF;
				end else add = 1'b1;
			end
			default: begin
			end
		endcase
		if (clr) s.tok = '0;
		if (add) begin
			if (!nz) s.tok.first = c;
			s.tok.last  = c;
			s.tok.count = (&t.count) ? t.count : t.count + 1'b1;
		end
		s.len = s.tok.count;
		if (s.emit) begin
			s.tok = '0;
			if (s.next == m) s.next = M_DEF;
		end
		s.start = (m == M_DEF) && (s.next != M_DEF);
		return s;
	endfunction

	// input register
	logic               valid_s1;
	sbt_pkg::src_item_t item_s1;

	// lexer state
	mode_t                  mode_q;
	tok_t                   tok_q;
	logic [OFFSET_BITS-1:0] tstart_off_q;
	logic [LINE_BITS-1:0]   tstart_line_q;
	logic [COLUMN_BITS-1:0] tstart_col_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;

	// result queue
	sbt_pkg::res_item_t fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fifo_cnt_q;

	logic                   fire;
	logic                   pop;
	logic                   is_end;
	logic [7:0]             c;
	step_t                  p1;
	step_t                  p2;
	step_t                  fin;
	step_t                  src;
	logic                   tok_res_v;
	logic                   halt_next;
	logic                   start_cap;
	logic [1:0]             res_n;
	sbt_pkg::res_item_t     res0;
	sbt_pkg::res_item_t     res1;
	sbt_pkg::res_item_t     tok_r;
	sbt_pkg::res_item_t     end_r;
	logic [LENGTH_BITS-1:0] open_len;

	assign pop       = res_valid && res_ready;
	assign res_valid = fifo_cnt_q != '0;
	assign res_data  = fifo_q[rd_ptr_q];
	assign fire      = valid_s1 && (fifo_cnt_q <= CNT_W'(2));
	assign src_ready = !valid_s1 || fire;

	always_comb begin
		is_end    = item_s1.kind == sbt_pkg::IN_END;
		c         = is_end ? CH_NL : item_s1.byte_value;
		p1        = lex_step(mode_q, tok_q, c);
		p2        = lex_step(p1.next, p1.tok, c);
		fin       = p1.rep ? p2 : p1;
		src       = (p1.emit || p1.err) ? p1 : p2;
		tok_res_v = p1.emit || p1.err || (p1.rep && (p2.emit || p2.err));
		halt_next = p1.err || (p1.rep && p2.err);
		start_cap = p1.start || (p1.rep && p2.start);

		tok_r.result_kind  = src.kind;
		tok_r.start_offset = sbt_pkg::offset_field_t'(tstart_off_q);
		tok_r.token_length = sbt_pkg::length_field_t'(src.len);
		tok_r.start_line   = sbt_pkg::line_field_t'(tstart_line_q);
		tok_r.start_column = sbt_pkg::column_field_t'(tstart_col_q);
		tok_r.last_of_run  = !is_end;

		open_len = (|fin.tok.count) ? fin.tok.count - 1'b1 : '0;
		end_r.last_of_run = 1'b1;
		priority if ((fin.next == M_STR) || (fin.next == M_CHR)) begin
			end_r.result_kind  = (fin.next == M_STR) ? sbt_pkg::RK_OPEN_STR
				: sbt_pkg::RK_OPEN_CHR;
			end_r.start_offset = sbt_pkg::offset_field_t'(tstart_off_q);
			end_r.token_length = sbt_pkg::length_field_t'(open_len);
			end_r.start_line   = sbt_pkg::line_field_t'(tstart_line_q);
			end_r.start_column = sbt_pkg::column_field_t'(tstart_col_q);
		end else begin
			end_r.result_kind  = (fin.next != M_DEF) ? sbt_pkg::RK_UNEXP_END
				: sbt_pkg::RK_DONE;
			end_r.start_offset = sbt_pkg::offset_field_t'(offset_q);
			end_r.token_length = (fin.next != M_DEF) ? sbt_pkg::length_field_t'(1) : '0;
			end_r.start_line   = sbt_pkg::line_field_t'(line_q);
			end_r.start_column = sbt_pkg::column_field_t'(col_q);
		end

		res0  = tok_r;
		res1  = end_r;
		res_n = 2'd0;
		if (mode_q != M_HALT) begin
			if (is_end) begin
				res0  = tok_res_v ? tok_r : end_r;
				res_n = tok_res_v ? 2'd2 : 2'd1;
			end else begin
				res_n = tok_res_v ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			mode_q        <= M_DEF;
			tok_q         <= '0;
			tstart_off_q  <= '0;
			tstart_line_q <= '0;
			tstart_col_q  <= '0;
			offset_q      <= '0;
			line_q        <= '0;
			col_q         <= '0;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			fifo_cnt_q    <= '0;
		end else begin
			if (src_ready) valid_s1 <= src_valid;
			if (fire) begin
				if (is_end) begin
					mode_q        <= M_DEF;
					tok_q         <= '0;
					tstart_off_q  <= '0;
					tstart_line_q <= '0;
					tstart_col_q  <= '0;
					offset_q      <= '0;
					line_q        <= '0;
					col_q         <= '0;
				end else if (mode_q != M_HALT) begin
					mode_q <= halt_next ? M_HALT : fin.next;
					tok_q  <= fin.tok;
					if (start_cap) begin
						tstart_off_q  <= offset_q;
						tstart_line_q <= line_q;
						tstart_col_q  <= col_q;
					end
					offset_q <= (&offset_q) ? offset_q : offset_q + 1'b1;
					if (c == CH_NL) begin
						line_q <= (&line_q) ? line_q : line_q + 1'b1;
						col_q  <= '0;
					end else begin
						col_q <= (&col_q) ? col_q : col_q + 1'b1;
					end
				end
			end
			wr_ptr_q   <= wr_ptr_q + (fire ? PTR_W'(res_n) : '0);
			rd_ptr_q   <= rd_ptr_q + (pop ? PTR_W'(1) : '0);
			fifo_cnt_q <= fifo_cnt_q + (fire ? CNT_W'(res_n) : '0) - (pop ? CNT_W'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) item_s1 <= src_data;
		if (fire && (res_n != 2'd0)) fifo_q[wr_ptr_q] <= res0;
		if (fire && (res_n == 2'd2)) fifo_q[PTR_W'(wr_ptr_q + 1'b1)] <= res1;
	end

	`SBT_ASSERT_NOW(a_queue_bound, 1'b1, fifo_cnt_q <= CNT_W'(FIFO_DEPTH), "result queue overrun")
	`SBT_ASSERT_NOW(a_halt_silent, fire && (mode_q == M_HALT), res_n == 2'd0,
		"result while halted")
	`SBT_ASSERT_NEXT(a_end_resets, fire && is_end,
		(mode_q == M_DEF) && (offset_q == '0) && (line_q == '0) && (col_q == '0),
		"end transaction left state behind")
	`SBT_ASSERT_NEXT(a_error_halts, fire && !is_end && (mode_q != M_HALT) && halt_next,
		mode_q == M_HALT, "bad digit did not halt")
	`SBT_ASSERT_NOW(a_run_marks, fire && (res_n == 2'd2),
		!res0.last_of_run && res1.last_of_run, "run end mark misplaced")

endmodule

// File: tb/sv/source_byte_tokenizer_unit_tb.sv
`timescale 1ns / 1ps

module source_byte_tokenizer_unit_tb;

	typedef enum logic [3:0] {
		LX_DEF, LX_IDENT, LX_HEX, LX_BIN, LX_OCT, LX_FLOAT, LX_DEC, LX_ZERO,
		LX_OPER, LX_STR, LX_CHR, LX_LCOM, LX_BCOM, LX_HALT
	} lex_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               src_valid;
	logic               src_ready;
	sbt_pkg::src_item_t src_data;
	logic               res_valid;
	logic               res_ready;
	sbt_pkg::res_item_t res_data;

	source_byte_tokenizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sbt_pkg::src_item_t     src_items[$];
	sbt_pkg::res_item_t     token_reports[$];
	sbt_pkg::res_item_t     want;
	int                     error_count = 0;
	int                     src_count = 0;
	bit                     src_took = 1'b0;
	int                     src_gap = 0;
	int                     src_calm = 0;
	int                     sink_gap = 0;
	int                     sink_calm = 0;
	int                     hold_cycles = 0;
	bit                     hold_done = 1'b0;

	lex_mode_t              lex_mode;
	logic [7:0]             tok_first;
	logic [7:0]             tok_last;
	sbt_pkg::length_field_t tok_count;
	sbt_pkg::offset_field_t tok_offset;
	sbt_pkg::line_field_t   tok_line;
	sbt_pkg::column_field_t tok_column;
	sbt_pkg::offset_field_t src_offset;
	sbt_pkg::line_field_t   src_line;
	sbt_pkg::column_field_t src_column;

	string op_forms[$] = {"=", "==", "!=", "<=", ">=", "<<", ">>", "<<=", ">>=", "??=",
		"->", "++", "--", "&&", "||", "::", "??", "+=", "-=", "*=", "/=", "%=",
		"(", ")", "{", "}", "[", "]", ";", ",", ".", "~", "^", "?", ":", "!",
		"&", "|", "%"};
	string op_set = "=!<>+-*/%&|^?:,.(){}[];~";

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_op(input logic [7:0] c);
		return c inside {"=", "!", "<", ">", "+", "-", "*", "/", "%", "&", "|", "^", "?",
			":", ",", ".", "(", ")", "{", "}", "[", "]", ";", "~"};
	endfunction

	function automatic bit op_extends(input logic [7:0] f, input sbt_pkg::length_field_t k,
			input logic [7:0] c);
		if (f == c && k == 1 && (c inside {":", "+", "-", "&", "|", "?", "<", ">"}))
			return 1'b1;
		if (c == "=" && k == 1 && (f inside {"<", ">", "=", "!", "+", "-", "/", "*", "%"}))
			return 1'b1;
		if (c == "=" && k == 2 && (f inside {"<", ">", "?"}))
			return 1'b1;
		return f == "-" && c == ">" && k == 1;
	endfunction

	function automatic void lexer_reset();
		lex_mode = LX_DEF;
		tok_first = '0;
		tok_last = '0;
		tok_count = '0;
		tok_offset = '0;
		tok_line = '0;
		tok_column = '0;
		src_offset = '0;
		src_line = '0;
		src_column = '0;
	endfunction

	function automatic void tok_clear();
		tok_count = '0;
		tok_first = '0;
		tok_last = '0;
	endfunction

	function automatic void tok_push(input logic [7:0] c);
		if (tok_count == 0)
			tok_first = c;
		tok_last = c;
		if (!(&tok_count))
			tok_count++;
	endfunction

	function automatic void report(input sbt_pkg::res_kind_t k,
			input sbt_pkg::offset_field_t off, input sbt_pkg::length_field_t len,
			input sbt_pkg::line_field_t line, input sbt_pkg::column_field_t col);
		sbt_pkg::res_item_t r;
		r.result_kind = k;
		r.start_offset = off;
		r.token_length = len;
		r.start_line = line;
		r.start_column = col;
		r.last_of_run = 1'b0;
		token_reports.insert(token_reports.size(), r);
	endfunction

	function automatic int scan_byte(input logic [7:0] c);
		int                 n;
		bit                 rescan, take, emit, halt;
		sbt_pkg::res_kind_t emit_kind;
		lex_mode_t          nxt;
		logic [7:0]         q;
		n = 0;
		for (int pass = 0; pass < 4; pass++) begin
			rescan = 1'b0;
			take = 1'b0;
			emit = 1'b0;
			halt = 1'b0;
			emit_kind = sbt_pkg::RK_IDENT;
			nxt = lex_mode;
			case (lex_mode)
				LX_DEF: begin
					take = 1'b1;
					if (c == "\"")
						nxt = LX_STR;
					else if (c == "'")
						nxt = LX_CHR;
					else if (c == "0")
						nxt = LX_ZERO;
					else if (is_op(c))
						nxt = LX_OPER;
					else if (is_digit(c))
						nxt = LX_DEC;
					else if (is_space(c)) begin
						take = 1'b0;
						tok_clear();
					end else
						nxt = LX_IDENT;
				end
				LX_IDENT: begin
					if (is_op(c) || is_space(c)) begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_IDENT;
					end else
						take = 1'b1;
				end
				LX_HEX: begin
					if (is_hex(c))
						take = 1'b1;
					else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_HEX;
					end
				end
				LX_BIN: begin
					if (c == "0" || c == "1")
						take = 1'b1;
					else if (is_digit(c)) begin
						halt = 1'b1;
						emit_kind = sbt_pkg::RK_BAD_BIN;
					end else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_BIN;
					end
				end
				LX_OCT: begin
					if (c >= "0" && c <= "7")
						take = 1'b1;
					else if (is_digit(c)) begin
						halt = 1'b1;
						emit_kind = sbt_pkg::RK_BAD_OCT;
					end else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_OCT;
					end
				end
				LX_FLOAT: begin
					if (is_digit(c))
						take = 1'b1;
					else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_FLOAT;
					end
				end
				LX_DEC: begin
					if (is_digit(c))
						take = 1'b1;
					else if (c == ".") begin
						take = 1'b1;
						nxt = LX_FLOAT;
					end else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_DEC;
					end
				end
				LX_ZERO: begin
					if (c == ".") begin
						take = 1'b1;
						nxt = LX_FLOAT;
					end else if (c == "b") begin
						take = 1'b1;
						nxt = LX_BIN;
					end else if (c == "x") begin
						take = 1'b1;
						nxt = LX_HEX;
					end else if (is_digit(c)) begin
						nxt = LX_OCT;
						rescan = 1'b1;
					end else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_DEC;
					end
				end
				LX_OPER: begin
					if (tok_count == 0)
						take = 1'b1;
					else if (tok_first == "." && is_digit(c)) begin
						take = 1'b1;
						nxt = LX_FLOAT;
					end else if (tok_first == "/" && tok_count == 1 && c == "/")
						nxt = LX_LCOM;
					else if (tok_first == "/" && tok_count == 1 && c == "*")
						nxt = LX_BCOM;
					else if (op_extends(tok_first, tok_count, c))
						take = 1'b1;
					else begin
						emit = 1'b1;
						emit_kind = sbt_pkg::RK_OPER;
					end
				end
				LX_STR, LX_CHR: begin
					q = (lex_mode == LX_STR) ? 8'h22 : 8'h27;
					take = 1'b1;
					if (c == q && !(tok_count > 0 && tok_last == "\\")) begin
						emit = 1'b1;
						emit_kind = (lex_mode == LX_STR) ? sbt_pkg::RK_STRING
							: sbt_pkg::RK_CHAR;
						nxt = LX_DEF;
					end
				end
				LX_LCOM: begin
					tok_clear();
					if (c == 8'h0A)
						nxt = LX_DEF;
				end
				LX_BCOM: begin
					if (c == "/" && tok_count > 0 && tok_last == "*") begin
						tok_clear();
						nxt = LX_DEF;
					end else
						take = 1'b1;
				end
				default: return n;
			endcase
			if (emit && !(lex_mode inside {LX_STR, LX_CHR}))
				rescan = 1'b1;
			if (halt) begin
				report(emit_kind, tok_offset, tok_count, tok_line, tok_column);
				lex_mode = LX_HALT;
				return n + 1;
			end
			if (take)
				tok_push(c);
			if (emit) begin
				report(emit_kind, tok_offset, tok_count, tok_line, tok_column);
				n++;
				tok_clear();
				if (nxt == lex_mode)
					nxt = LX_DEF;
			end
			if (lex_mode == LX_DEF && nxt != LX_DEF) begin
				tok_offset = src_offset;
				tok_line = src_line;
				tok_column = src_column;
			end
			lex_mode = nxt;
			if (!rescan)
				break;
		end
		return n;
	endfunction

	function automatic void tokenize_item(input sbt_pkg::src_item_t it);
		int n;
		n = 0;
		if (it.kind == sbt_pkg::IN_BYTE) begin
			if (lex_mode == LX_HALT)
				return;
			n = scan_byte(it.byte_value);
			if (!(&src_offset))
				src_offset++;
			if (it.byte_value == 8'h0A) begin
				if (!(&src_line))
					src_line++;
				src_column = '0;
			end else if (!(&src_column))
				src_column++;
		end else begin
			if (lex_mode == LX_HALT) begin
				lexer_reset();
				return;
			end
			n = scan_byte(8'h0A);
			if (lex_mode == LX_STR || lex_mode == LX_CHR)
				report(lex_mode == LX_STR ? sbt_pkg::RK_OPEN_STR : sbt_pkg::RK_OPEN_CHR,
					tok_offset, tok_count > 0 ? tok_count - 1'b1 : '0, tok_line,
					tok_column);
			else if (lex_mode != LX_DEF)
				report(sbt_pkg::RK_UNEXP_END, src_offset, 16'd1, src_line, src_column);
			else
				report(sbt_pkg::RK_DONE, src_offset, 16'd0, src_line, src_column);
			n++;
			lexer_reset();
		end
		if (n > 0)
			token_reports[token_reports.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_byte(input logic [7:0] b);
		sbt_pkg::src_item_t it;
		it.kind = sbt_pkg::IN_BYTE;
		it.byte_value = b;
		src_items.insert(src_items.size(), it);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_end();
		sbt_pkg::src_item_t it;
		it.kind = sbt_pkg::IN_END;
		it.byte_value = 8'($urandom_range(0, 255));
		src_items.insert(src_items.size(), it);
	endtask

	function automatic logic [7:0] pick_digit(input int hi);
		return 8'("0" + $urandom_range(0, hi));
	endfunction

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_ident_byte(input bit head);
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return pick_letter();
		if (r < 12)
			return "_";
		if (r < 15)
			return 8'($urandom_range(128, 255));
		if (r < 16)
			return 8'h00;
		if (r < 17)
			return "$";
		return head ? pick_letter() : pick_digit(9);
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 5))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0D;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return " ";
		endcase
	endfunction

	task automatic add_quoted(input logic [7:0] q, input int most, input bit closed);
		logic [7:0] c;
		add_byte(q);
		repeat ($urandom_range(0, most)) begin
			if ($urandom_range(0, 7) == 0) begin
				add_byte("\\");
				add_byte(8'($urandom_range(32, 126)));
			end else begin
				c = 8'($urandom_range(32, 126));
				add_byte((c == q || c == "\\") ? 8'h61 : c);
			end
		end
		if (closed)
			add_byte(q);
	endtask

	task automatic gen_token();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 16) begin
			add_byte(pick_ident_byte(1'b1));
			repeat ($urandom_range(0, 6))
				add_byte(pick_ident_byte(1'b0));
		end else if (sel < 22) begin
			add_text("0x");
			repeat ($urandom_range(0, 4))
				case ($urandom_range(0, 2))
					0: add_byte(8'("a" + $urandom_range(0, 5)));
					1: add_byte(8'("A" + $urandom_range(0, 5)));
					default: add_byte(pick_digit(9));
				endcase
		end else if (sel < 27) begin
			add_text("0b");
			repeat ($urandom_range(0, 5))
				add_byte(pick_digit(1));
		end else if (sel < 32) begin
			add_byte("0");
			repeat ($urandom_range(1, 4))
				add_byte(pick_digit(7));
		end else if (sel < 38) begin
			case ($urandom_range(0, 2))
				0: begin
					repeat ($urandom_range(1, 3))
						add_byte(pick_digit(9));
					add_byte(".");
				end
				1: add_byte(".");
				default: add_text("0.");
			endcase
			repeat ($urandom_range(0, 3))
				add_byte(pick_digit(9));
		end else if (sel < 48) begin
			if ($urandom_range(0, 3) == 0)
				add_byte("0");
			else begin
				add_byte(8'("1" + $urandom_range(0, 8)));
				repeat ($urandom_range(0, 4))
					add_byte(pick_digit(9));
			end
		end else if (sel < 68) begin
			if ($urandom_range(0, 9) < 7)
				add_text(op_forms[$urandom_range(0, op_forms.size() - 1)]);
			else
				repeat ($urandom_range(1, 3))
					add_byte(op_set[$urandom_range(0, op_set.len() - 1)]);
		end else if (sel < 75) begin
			add_quoted(8'h22, 8, 1'b1);
		end else if (sel < 80) begin
			add_quoted(8'h27, 2, 1'b1);
		end else if (sel < 84) begin
			add_text("//");
			repeat ($urandom_range(0, 10))
				add_byte(8'($urandom_range(32, 126)));
			add_byte(8'h0A);
		end else if (sel < 88) begin
			add_text("/*");
			repeat ($urandom_range(0, 10))
				add_byte($urandom_range(0, 15) == 0 ? 8'h0A : 8'($urandom_range(32, 126)));
			add_text("*/");
		end else if (sel < 94) begin
			repeat ($urandom_range(1, 3))
				add_byte(pick_space());
		end else
			add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic gen_source();
		int r;
		repeat ($urandom_range(1, 20)) begin
			gen_token();
			r = $urandom_range(0, 99);
			if (r < 50)
				add_byte(" ");
			else if (r < 65)
				add_byte(8'h0A);
			else if (r < 72)
				add_byte(pick_space());
		end
		case ($urandom_range(0, 19))
			0: begin
				add_text("0b");
				repeat ($urandom_range(0, 3))
					add_byte(pick_digit(1));
				add_byte(8'("2" + $urandom_range(0, 7)));
			end
			1: begin
				add_byte("0");
				repeat ($urandom_range(0, 3))
					add_byte(pick_digit(7));
				add_byte(8'("8" + $urandom_range(0, 1)));
			end
			2: add_quoted(8'h22, 6, 1'b0);
			3: add_quoted(8'h27, 2, 1'b0);
			4: begin
				add_text("/*");
				repeat ($urandom_range(0, 6))
					add_byte(8'($urandom_range(32, 126)));
			end
			5: repeat ($urandom_range(1, 10))
				add_byte(8'($urandom_range(0, 255)));
			default: ;
		endcase
		add_end();
	endtask

	task automatic check_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, what, want_v, got_v);
		end
	endtask

	// Check results, then record the transaction on the source side.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (token_reports.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d offset %0d",
					$time, res_data.result_kind, res_data.start_offset);
			end else begin
				want = token_reports.pop_front();
				check_field("result_kind", 32'(want.result_kind),
					32'(res_data.result_kind));
				check_field("start_offset", want.start_offset, res_data.start_offset);
				check_field("token_length", 32'(want.token_length),
					32'(res_data.token_length));
				check_field("start_line", 32'(want.start_line), 32'(res_data.start_line));
				check_field("start_column", 32'(want.start_column),
					32'(res_data.start_column));
				check_field("last_of_run", 32'(want.last_of_run),
					32'(res_data.last_of_run));
			end
		end
		src_took = arst_n && src_valid && src_ready;
		if (src_took) begin
			tokenize_item(src_data);
			src_count++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!src_valid || src_took)) begin
			if (src_gap > 0) begin
				src_gap--;
				src_valid <= 1'b0;
			end else if (src_items.size() != 0) begin
				src_data <= src_items.pop_front();
				src_valid <= 1'b1;
				src_gap = pick_gap(src_calm);
			end else
				src_valid <= 1'b0;
		end
	end

	// Hold off the sink once for a long stretch so the block backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ready <= 1'b0;
			end else if (!hold_done && src_count >= 300) begin
				hold_done = 1'b1;
				hold_cycles = 400;
				res_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				sink_gap = pick_gap(sink_calm);
			end
		end
	end

	initial begin
		int target;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_data = '0;
		res_ready = 1'b0;
		lexer_reset();

		add_text("0b12z");
		add_end();
		add_text("09");
		add_end();
		add_text("\"a");
		add_end();
		add_text("'");
		add_end();
		add_text("/*");
		add_end();
		add_byte(8'h00);
		add_byte(8'hFF);
		add_end();
		add_end();

		target = 610;
		while (src_items.size() < target)
			gen_source();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (src_items.size() != 0 || src_valid)
			@(negedge clk);
		while (token_reports.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
